FILE: rtl/sample_fifo_with_drop_policy_macros.svh
// ----------------------------------------------------------------------------
// Sample FIFO assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_FIFO_WITH_DROP_POLICY_MACROS_SVH
`define SAMPLE_FIFO_WITH_DROP_POLICY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: cond holds whenever trig holds.
`define SFDP_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("sfdp check failed");

// Next-cycle implication: cond holds in the cycle after trig.
`define SFDP_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("sfdp check failed");

`else

`define SFDP_ASSERT_SAME(lbl, clk, rst_n, trig, cond)
`define SFDP_ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

FILE: rtl/sfdp_pkg.sv
// ----------------------------------------------------------------------------
// Sample FIFO package
// Sizes, item types, status codes and register indexes shared by the RTL.
// ----------------------------------------------------------------------------
package sfdp_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEVEL_W = $clog2(DEPTH + 1);

    localparam int VALUE_W = 16;
    localparam int UID_W   = 8;
    localparam int ENTRY_W = VALUE_W + UID_W;
    localparam int OCC_W   = 7;
    localparam int COUNT_W = 32;

    // configuration port
    localparam int CAP_W      = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = (LEVEL_W > CAP_W) ? LEVEL_W : CAP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_OLDEST = CFG_IDX_W'(1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECTED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] sample_value;
        logic        [UID_W-1:0]   sample_uid;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] out_value;
        logic        [UID_W-1:0]   out_uid;
        logic        [OCC_W-1:0]   occupancy;
        logic        [OCC_W-1:0]   high_water;
        logic        [COUNT_W-1:0] received_count;
        logic        [COUNT_W-1:0] released_count;
        logic        [COUNT_W-1:0] dropped_count;
    } t_out_item;

endpackage

FILE: rtl/sample_fifo_with_drop_policy.sv
// ----------------------------------------------------------------------------
// Sample FIFO with drop policy
// Bounded ring of sensor samples; a push on a full queue is either
// rejected or replaces the oldest sample, selected by a register.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload
//  --------  --------------------------  ----------------------------------
//  input     i_start while !o_busy       i_item   (mode, value, uid)
//  result    o_done, one-cycle strobe    o_result (status, sample, stats)
//  config    i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
//  An accepted item gives its result in the very next cycle; one item can
//  be accepted every cycle. The sample RAM read port sets that latency.
//  o_busy is high only while reset is asserted. Reset is synchronous and
//  clears pointers, level, peak, counters and registers; RAM contents are
//  left as they are. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "sample_fifo_with_drop_policy_macros.svh"

module sample_fifo_with_drop_policy (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  sfdp_pkg::t_in_item                  i_item,
    output logic                                o_busy,
    output logic                                o_done,
    output sfdp_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_we,
    input  logic [sfdp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sfdp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import sfdp_pkg::*;

    // configuration registers
    logic [CAP_W-1:0]   r_cap;
    logic               r_drop;

    // queue state
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [ADDR_W-1:0]  r_tail, n_tail;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [LEVEL_W-1:0] r_peak, n_peak;
    logic [COUNT_W-1:0] r_rcvd, n_rcvd;
    logic [COUNT_W-1:0] r_rels, n_rels;
    logic [COUNT_W-1:0] r_drpd, n_drpd;

    // result register
    logic               r_done;
    logic               r_pop_ok, n_pop_ok;
    t_status            r_status, n_status;

    logic               accept;
    logic               is_push;
    logic               full;
    logic               empty;
    logic               do_append;
    logic               do_take;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   cap_ext;
    logic [ENTRY_W-1:0] rd_entry;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
        return (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + ADDR_W'(1);
    endfunction

    assign o_busy = ~i_rst_n;
    assign accept = i_start & ~o_busy;

    // Capacity of zero behaves as one; anything above the ring size clamps.
    assign cap_ext = CMP_W'(r_cap);
    always_comb begin
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            cap_eff = CMP_W'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    // Full also covers a capacity lowered below the current level.
    assign is_push = (i_item.mode == MODE_PUSH);
    assign full    = (CMP_W'(r_level) >= cap_eff);
    assign empty   = (r_level == '0);

    always_comb begin
        do_append = 1'b0;
        do_take   = 1'b0;
        n_pop_ok  = 1'b0;
        n_status  = ST_OK;
        if (is_push) begin
            if (!full) begin
                do_append = 1'b1;
            end else if (r_drop) begin
                // drop the head, then append the new sample
                do_take   = 1'b1;
                do_append = 1'b1;
                n_status  = ST_DROPPED;
            end else begin
                n_status  = ST_REJECTED;
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                do_take  = 1'b1;
                n_pop_ok = 1'b1;
            end
        end
    end

    always_comb begin
        n_head  = do_take   ? ring_next(r_head) : r_head;
        n_tail  = do_append ? ring_next(r_tail) : r_tail;
        n_level = r_level + LEVEL_W'(do_append) - LEVEL_W'(do_take);
        n_peak  = (do_append && (n_level > r_peak)) ? n_level : r_peak;
        n_rcvd  = r_rcvd + COUNT_W'(do_append);
        n_rels  = r_rels + COUNT_W'(do_take);
        n_drpd  = r_drpd + COUNT_W'(do_take & is_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_drop   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_level  <= '0;
            r_peak   <= '0;
            r_rcvd   <= '0;
            r_rels   <= '0;
            r_drpd   <= '0;
            r_done   <= 1'b0;
            r_pop_ok <= 1'b0;
            r_status <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPACITY:    r_cap  <= i_cfg_wdata[CAP_W-1:0];
                    CFG_DROP_OLDEST: r_drop <= i_cfg_wdata[0];
                    default:         ;
                endcase
            end
            r_done <= accept;
            if (accept) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_level  <= n_level;
                r_peak   <= n_peak;
                r_rcvd   <= n_rcvd;
                r_rels   <= n_rels;
                r_drpd   <= n_drpd;
                r_pop_ok <= n_pop_ok;
                r_status <= n_status;
            end
        end
    end

    // The head entry is read on every accepted item; the registered data
    // lines up with the result cycle and is used only for a good pop.
    sfdp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept & do_append),
        .i_waddr (r_tail),
        .i_wdata ({i_item.sample_uid, i_item.sample_value}),
        .i_re    (accept),
        .i_raddr (r_head),
        .o_rdata (rd_entry)
    );

    // Statistics registers already hold the post-item values.
    always_comb begin
        o_result.status         = r_status;
        o_result.out_value      = r_pop_ok ? rd_entry[VALUE_W-1:0] : '0;
        o_result.out_uid        = r_pop_ok ? rd_entry[ENTRY_W-1:VALUE_W] : '0;
        o_result.occupancy      = OCC_W'(r_level);
        o_result.high_water     = OCC_W'(r_peak);
        o_result.received_count = r_rcvd;
        o_result.released_count = r_rels;
        o_result.dropped_count  = r_drpd;
    end

    assign o_done = r_done;

    `SFDP_ASSERT_SAME(a_level_bound, i_clk, i_rst_n, 1'b1, r_level <= LEVEL_W'(DEPTH))
    `SFDP_ASSERT_SAME(a_peak_covers, i_clk, i_rst_n, 1'b1, r_peak >= r_level)
    `SFDP_ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, accept, o_done)
    `SFDP_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !accept, !o_done)
    `SFDP_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, accept && !is_push && !empty, r_level == $past(r_level) - LEVEL_W'(1))
    `SFDP_ASSERT_NEXT(a_drop_keeps, i_clk, i_rst_n, accept && is_push && full && r_drop, r_level == $past(r_level) && r_status == ST_DROPPED)

endmodule

FILE: rtl/sfdp_ram.sv
// ----------------------------------------------------------------------------
// Sample FIFO RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module sfdp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                               i_wdata,
    input  logic                                           i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
